// File: design/cpa_pkg.sv
// Package for the plus-shaped polygon area and hit test block.
// Coordinate and arithmetic types, action and result codes, shared structs.
// No dependencies.
package cpa_pkg;

   localparam int COORD_WIDTH  = 16;                       // internal coordinate width
   localparam int PORT_COORD_W = 16;                       // width of the coordinate ports
   localparam int NUM_CORNERS  = 12;
   localparam int ADDR_W       = $clog2(NUM_CORNERS);
   localparam int LAST_CORNER  = NUM_CORNERS - 1;
   localparam int NUM_TERMS    = 5;
   localparam int TERM_W       = $clog2(NUM_TERMS);
   localparam int LAST_TERM    = NUM_TERMS - 1;
   localparam int AREA_W       = 32;
   localparam int DIFF_W       = COORD_WIDTH + 1;
   localparam int PROD_W       = 2 * DIFF_W;
   localparam int ACC_W        = PROD_W + 3;
   localparam int CLAMP_W      = (ACC_W > AREA_W + 2) ? ACC_W : AREA_W + 2;

   // extremes: west (x min), east (x max), south (y min), north (y max)
   localparam int NUM_EXT = 4;
   localparam int EXT_W   = 0;
   localparam int EXT_E   = 1;
   localparam int EXT_S   = 2;
   localparam int EXT_N   = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]      diff_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [ACC_W-1:0]       acc_type;
   typedef logic signed [CLAMP_W-1:0]     clamp_type;
   typedef logic [ADDR_W-1:0]             addr_type;
   typedef logic [TERM_W-1:0]             term_type;
   typedef logic [1:0]                    ext_cnt_type;
   typedef logic [AREA_W-1:0]             area_type;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_FINISH = 2'd1,
      ACT_QUERY  = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   localparam logic KIND_AREA  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // area terms, one rectangle each
   localparam term_type TERM_NORTH  = term_type'(0);
   localparam term_type TERM_SOUTH  = term_type'(1);
   localparam term_type TERM_WEST   = term_type'(2);
   localparam term_type TERM_EAST   = term_type'(3);
   localparam term_type TERM_MIDDLE = term_type'(4);

   typedef struct packed {
      coord_type x_lo;
      coord_type x_hi;
      coord_type y_lo;
      coord_type y_hi;
      coord_type w_ylo;
      coord_type w_yhi;
      coord_type e_ylo;
      coord_type e_yhi;
      coord_type s_xlo;
      coord_type s_xhi;
      coord_type n_xlo;
      coord_type n_xhi;
      coord_type c_yhi;
      coord_type c_ylo;
      coord_type c_xlo;
      coord_type c_xhi;
   } bounds_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      coord_type x;
      coord_type y;
   } vtx_wr_type;

   typedef struct packed {
      logic     en;
      addr_type addr;
   } vtx_rd_type;

   typedef struct packed {
      logic     done;
      logic     valid;
      area_type area;
   } fin_rsp_type;

   // low COORD_WIDTH bits of a port word; zero extended when wider than the port
   function automatic coord_type to_coord(input logic [PORT_COORD_W-1:0] v);
      logic [COORD_WIDTH+PORT_COORD_W-1:0] wide;
      wide = {{COORD_WIDTH{1'b0}}, v};
      return coord_type'(wide[COORD_WIDTH-1:0]);
   endfunction

endpackage

// File: design/cpa_vertex_ram.sv
// Corner store: twelve x/y pairs, one write and one registered read per cycle.
// Entries never written read as zero through per-entry valid bits. Uses cpa_pkg.
module cpa_vertex_ram
   import cpa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  vtx_wr_type wr,
   input  vtx_rd_type rd,
   output coord_type  rd_x,
   output coord_type  rd_y
);

   coord_type               x_mem [NUM_CORNERS];
   coord_type               y_mem [NUM_CORNERS];
   logic [NUM_CORNERS-1:0]  vld_ff;
   coord_type               rd_x_ff;
   coord_type               rd_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         x_mem[wr.addr] <= wr.x;
         y_mem[wr.addr] <= wr.y;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_x_ff <= vld_ff[rd.addr] ? x_mem[rd.addr] : '0;
         rd_y_ff <= vld_ff[rd.addr] ? y_mem[rd.addr] : '0;
      end
   end

   assign rd_x = rd_x_ff;
   assign rd_y = rd_y_ff;

endmodule

// File: design/cpa_finish.sv
// Finish sequencer: two passes over the corner store, dividing lines,
// five-term area on one shared multiplier, clamp. Holds the shape registers. Uses cpa_pkg.
module cpa_finish
   import cpa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  coord_type   rd_x,
   input  coord_type   rd_y,
   output vtx_rd_type  rd,
   output logic        busy,
   output bounds_type  bounds,
   output logic        shape_valid,
   output area_type    shape_area,
   output fin_rsp_type fin_rsp
);

   typedef enum logic [7:0] {
      FS_IDLE    = 8'b0000_0001,
      FS_MINMAX  = 8'b0000_0010,
      FS_COLLECT = 8'b0000_0100,
      FS_SORT    = 8'b0000_1000,
      FS_LINES   = 8'b0001_0000,
      FS_MUL     = 8'b0010_0000,
      FS_ACCUM   = 8'b0100_0000,
      FS_REPORT  = 8'b1000_0000
   } fin_state_type;

   fin_state_type state_ff, state_in;
   addr_type      addr_ff, addr_in;
   term_type      term_ff, term_in;
   logic          p1_vld_ff, p1_first_ff, p2_vld_ff;
   logic          prod_vld_ff;
   logic          ok_ff, ok_in;
   bounds_type    bounds_ff, bounds_in;
   logic          valid_ff;
   area_type      area_ff, area_in;

   coord_type     xmin_ff, xmax_ff, ymin_ff, ymax_ff;
   ext_cnt_type   ext_cnt_ff [NUM_EXT];
   coord_type     ext_a_ff   [NUM_EXT];
   coord_type     ext_b_ff   [NUM_EXT];
   logic          hit        [NUM_EXT];
   coord_type     val        [NUM_EXT];
   coord_type     ext_lo     [NUM_EXT];
   coord_type     ext_hi     [NUM_EXT];
   diff_type      fac_a, fac_b;
   prod_type      prod_ff;
   acc_type       acc_ff;
   clamp_type     acc_ext;

   // ---- sequencer ----
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      term_in  = term_ff;
      unique case (state_ff)
         FS_IDLE: begin
            addr_in = '0;
            if (start) state_in = FS_MINMAX;
         end
         FS_MINMAX: begin
            addr_in = addr_ff + addr_type'(1);
            if (addr_ff == addr_type'(LAST_CORNER)) begin
               addr_in  = '0;
               state_in = FS_COLLECT;
            end
         end
         FS_COLLECT: begin
            addr_in = addr_ff + addr_type'(1);
            if (addr_ff == addr_type'(LAST_CORNER)) begin
               addr_in  = '0;
               state_in = FS_SORT;
            end
         end
         FS_SORT: begin
            state_in = FS_LINES;
         end
         FS_LINES: begin
            term_in  = '0;
            state_in = ok_in ? FS_MUL : FS_REPORT;
         end
         FS_MUL: begin
            term_in = term_ff + term_type'(1);
            if (term_ff == term_type'(LAST_TERM)) state_in = FS_ACCUM;
         end
         FS_ACCUM: begin
            state_in = FS_REPORT;
         end
         FS_REPORT: begin
            state_in = FS_IDLE;
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   assign rd.en   = (state_ff == FS_MINMAX) || (state_ff == FS_COLLECT);
   assign rd.addr = addr_ff;
   assign busy    = (state_ff != FS_IDLE);

   // ---- pass two: which extremes this corner sits on ----
   always_comb begin
      hit[EXT_W] = (rd_x == xmin_ff);
      hit[EXT_E] = (rd_x != xmin_ff) && (rd_x == xmax_ff);
      hit[EXT_S] = (rd_y == ymin_ff);
      hit[EXT_N] = (rd_y != ymin_ff) && (rd_y == ymax_ff);
      val[EXT_W] = rd_y;
      val[EXT_E] = rd_y;
      val[EXT_S] = rd_x;
      val[EXT_N] = rd_x;
   end

   // ---- sorted pairs and dividing lines ----
   always_comb begin
      ok_in = 1'b1;
      for (int i = 0; i < NUM_EXT; i++) begin
         ext_lo[i] = (ext_a_ff[i] < ext_b_ff[i]) ? ext_a_ff[i] : ext_b_ff[i];
         ext_hi[i] = (ext_a_ff[i] < ext_b_ff[i]) ? ext_b_ff[i] : ext_a_ff[i];
         if (ext_cnt_ff[i] != 2'd2) ok_in = 1'b0;
      end
      bounds_in.x_lo  = xmin_ff;
      bounds_in.x_hi  = xmax_ff;
      bounds_in.y_lo  = ymin_ff;
      bounds_in.y_hi  = ymax_ff;
      bounds_in.w_ylo = ext_lo[EXT_W];
      bounds_in.w_yhi = ext_hi[EXT_W];
      bounds_in.e_ylo = ext_lo[EXT_E];
      bounds_in.e_yhi = ext_hi[EXT_E];
      bounds_in.s_xlo = ext_lo[EXT_S];
      bounds_in.s_xhi = ext_hi[EXT_S];
      bounds_in.n_xlo = ext_lo[EXT_N];
      bounds_in.n_xhi = ext_hi[EXT_N];
      bounds_in.c_yhi = (ext_hi[EXT_W] > ext_hi[EXT_E]) ? ext_hi[EXT_W] : ext_hi[EXT_E];
      bounds_in.c_ylo = (ext_lo[EXT_W] < ext_lo[EXT_E]) ? ext_lo[EXT_W] : ext_lo[EXT_E];
      bounds_in.c_xlo = (ext_lo[EXT_N] < ext_lo[EXT_S]) ? ext_lo[EXT_N] : ext_lo[EXT_S];
      bounds_in.c_xhi = (ext_hi[EXT_N] > ext_hi[EXT_S]) ? ext_hi[EXT_N] : ext_hi[EXT_S];
   end

   // ---- area term operands ----
   always_comb begin
      fac_a = '0;
      fac_b = '0;
      case (term_ff)
         TERM_NORTH: begin
            fac_a = diff_type'(bounds_ff.y_hi)  - diff_type'(bounds_ff.c_yhi);
            fac_b = diff_type'(bounds_ff.n_xhi) - diff_type'(bounds_ff.n_xlo);
         end
         TERM_SOUTH: begin
            fac_a = diff_type'(bounds_ff.c_ylo) - diff_type'(bounds_ff.y_lo);
            fac_b = diff_type'(bounds_ff.s_xhi) - diff_type'(bounds_ff.s_xlo);
         end
         TERM_WEST: begin
            fac_a = diff_type'(bounds_ff.c_xlo) - diff_type'(bounds_ff.x_lo);
            fac_b = diff_type'(bounds_ff.w_yhi) - diff_type'(bounds_ff.w_ylo);
         end
         TERM_EAST: begin
            fac_a = diff_type'(bounds_ff.x_hi)  - diff_type'(bounds_ff.c_xhi);
            fac_b = diff_type'(bounds_ff.e_yhi) - diff_type'(bounds_ff.e_ylo);
         end
         TERM_MIDDLE: begin
            fac_a = diff_type'(bounds_ff.c_xhi) - diff_type'(bounds_ff.c_xlo);
            fac_b = diff_type'(bounds_ff.c_yhi) - diff_type'(bounds_ff.c_ylo);
         end
         default: begin
            fac_a = '0;
            fac_b = '0;
         end
      endcase
   end

   // ---- clamp to the unsigned area range ----
   always_comb begin
      acc_ext = clamp_type'(acc_ff);
      if (!ok_ff || acc_ext < 0) begin
         area_in = '0;
      end else if (acc_ext[CLAMP_W-1:AREA_W] != '0) begin
         area_in = '1;
      end else begin
         area_in = acc_ext[AREA_W-1:0];
      end
   end

   // ---- control and shape registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= FS_IDLE;
         addr_ff     <= '0;
         term_ff     <= '0;
         p1_vld_ff   <= 1'b0;
         p1_first_ff <= 1'b0;
         p2_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         ok_ff       <= 1'b0;
         bounds_ff   <= '0;
         valid_ff    <= 1'b0;
         area_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         addr_ff     <= addr_in;
         term_ff     <= term_in;
         p1_vld_ff   <= (state_ff == FS_MINMAX);
         p1_first_ff <= (state_ff == FS_MINMAX) && (addr_ff == '0);
         p2_vld_ff   <= (state_ff == FS_COLLECT);
         prod_vld_ff <= (state_ff == FS_MUL);
         if (state_ff == FS_LINES) begin
            ok_ff     <= ok_in;
            bounds_ff <= ok_in ? bounds_in : '0;
         end
         if (state_ff == FS_REPORT) begin
            valid_ff <= ok_ff;
            area_ff  <= area_in;
         end
      end
   end

   // ---- datapath registers ----
   always_ff @(posedge clock) begin
      if (state_ff == FS_IDLE && start) begin
         for (int i = 0; i < NUM_EXT; i++) ext_cnt_ff[i] <= '0;
      end
      if (p1_vld_ff) begin
         if (p1_first_ff) begin
            xmin_ff <= rd_x;
            xmax_ff <= rd_x;
            ymin_ff <= rd_y;
            ymax_ff <= rd_y;
         end else begin
            if (rd_x < xmin_ff) xmin_ff <= rd_x;
            if (rd_x > xmax_ff) xmax_ff <= rd_x;
            if (rd_y < ymin_ff) ymin_ff <= rd_y;
            if (rd_y > ymax_ff) ymax_ff <= rd_y;
         end
      end
      if (p2_vld_ff) begin
         for (int i = 0; i < NUM_EXT; i++) begin
            if (hit[i]) begin
               if (ext_cnt_ff[i] == 2'd0) ext_a_ff[i] <= val[i];
               if (ext_cnt_ff[i] == 2'd1) ext_b_ff[i] <= val[i];
               if (ext_cnt_ff[i] != 2'd3) ext_cnt_ff[i] <= ext_cnt_ff[i] + 2'd1;
            end
         end
      end
      if (state_ff == FS_MUL) begin
         prod_ff <= prod_type'(fac_a) * prod_type'(fac_b);
      end
      if (state_ff == FS_LINES) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + acc_type'(prod_ff);
      end
   end

   assign bounds        = bounds_ff;
   assign shape_valid   = valid_ff;
   assign shape_area    = area_ff;
   assign fin_rsp.done  = (state_ff == FS_REPORT);
   assign fin_rsp.valid = ok_ff;
   assign fin_rsp.area  = area_in;

endmodule

// File: design/cpa_hit.sv
// Point hit test against the stored dividing lines: ordered arm tests for
// strict interior, twelve open edge segments. Uses cpa_pkg.
module cpa_hit
   import cpa_pkg::*;
(
   input  bounds_type b,
   input  logic       shape_valid,
   input  coord_type  x,
   input  coord_type  y,
   output logic       inside_res,
   output logic       on_edge
);

   logic inside_raw;
   logic edge_raw;

   // arms are tried in order; the first one whose band holds the point decides
   always_comb begin
      inside_raw = 1'b0;
      if (b.x_lo < x && x <= b.c_xlo) begin
         inside_raw = (b.w_ylo < y) && (y < b.w_yhi);
      end else if (b.c_yhi <= y && y < b.y_hi) begin
         inside_raw = (b.n_xlo < x) && (x < b.n_xhi);
      end else if (b.c_xhi <= x && x < b.x_hi) begin
         inside_raw = (b.e_ylo < y) && (y < b.e_yhi);
      end else if (b.y_lo < y && y <= b.c_ylo) begin
         inside_raw = (b.s_xlo < x) && (x < b.s_xhi);
      end else if (b.c_ylo <= y && y <= b.c_yhi) begin
         inside_raw = (b.c_xlo <= x) && (x <= b.c_xhi);
      end
   end

   always_comb begin
      edge_raw =
           ((x == b.x_lo)  && (b.w_ylo < y) && (y < b.w_yhi))
        || ((x == b.x_hi)  && (b.e_ylo < y) && (y < b.e_yhi))
        || ((x == b.n_xlo) && (b.w_yhi < y) && (y < b.y_hi))
        || ((x == b.n_xhi) && (b.e_yhi < y) && (y < b.y_hi))
        || ((x == b.s_xlo) && (b.y_lo < y)  && (y < b.w_ylo))
        || ((x == b.s_xhi) && (b.y_lo < y)  && (y < b.e_ylo))
        || ((y == b.y_hi)  && (b.n_xlo < x) && (x < b.n_xhi))
        || ((y == b.y_lo)  && (b.s_xlo < x) && (x < b.s_xhi))
        || ((y == b.w_yhi) && (b.x_lo < x)  && (x < b.n_xlo))
        || ((y == b.w_ylo) && (b.x_lo < x)  && (x < b.s_xlo))
        || ((y == b.e_yhi) && (b.n_xhi < x) && (x < b.x_hi))
        || ((y == b.e_ylo) && (b.s_xhi < x) && (x < b.x_hi));
   end

   assign inside_res = shape_valid && inside_raw;
   assign on_edge    = shape_valid && edge_raw;

endmodule

// File: design/cross_polygon_area_and_hit_test.sv
// Top level of the plus-shaped polygon area and hit test block.
// Instantiates cpa_vertex_ram, cpa_finish and cpa_hit; uses cpa_pkg.
//
// Usage: a word is taken on a rising edge with start high and busy low. Load
// words (action 0) write one of twelve corners, one per cycle, and give no
// result; a load index above eleven is dropped. A query word (action 2) is
// taken back to back, and its answer appears on the rsp_ ports
// in the next cycle. A finish word (action 1) walks the corner store twice
// through its single read port (12 reads to find the extents, 12 reads to
// gather the corners on each extreme), then derives the dividing lines and
// runs the five rectangle products through one shared multiplier (skipped
// when the shape turns out invalid); busy stays high meanwhile and the area
// report is shown in the same cycle that busy falls.
// Every result is shown for exactly one cycle with rsp_strobe high; there
// is no back-pressure, so the receiver must take it then. Query answers use
// the shape from the last finish; before any finish the shape is invalid.
module cross_polygon_area_and_hit_test
   import cpa_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_action,
   input  logic [3:0]                     req_vertex_index,
   input  logic signed [PORT_COORD_W-1:0] req_point_x,
   input  logic signed [PORT_COORD_W-1:0] req_point_y,
   output logic                           rsp_strobe,
   output logic                           rsp_result_kind,
   output logic                           rsp_shape_valid,
   output logic [AREA_W-1:0]              rsp_area,
   output logic                           rsp_inside_res,
   output logic                           rsp_on_edge
);

   logic        accept;
   logic        do_finish;
   logic        do_query;
   coord_type   px;
   coord_type   py;
   vtx_wr_type  vtx_wr;
   vtx_rd_type  vtx_rd;
   coord_type   rd_x;
   coord_type   rd_y;
   bounds_type  bounds;
   logic        shape_valid;
   area_type    shape_area;
   fin_rsp_type fin_rsp;
   logic        hit_inside;
   logic        hit_edge;

   logic        strobe_ff;
   logic        kind_ff;
   logic        valid_ff;
   area_type    area_ff;
   logic        inside_ff;
   logic        edge_ff;

   assign accept    = start && !busy;
   assign do_finish = accept && (req_action == ACT_FINISH);
   assign do_query  = accept && (req_action == ACT_QUERY);
   assign px        = to_coord(req_point_x);
   assign py        = to_coord(req_point_y);

   // corner write: only in-range indexes land in the store
   assign vtx_wr.en   = accept && (req_action == ACT_LOAD)
                        && (req_vertex_index < 4'(NUM_CORNERS));
   assign vtx_wr.addr = addr_type'(req_vertex_index);
   assign vtx_wr.x    = px;
   assign vtx_wr.y    = py;

   cpa_vertex_ram u_ram (
      .clock (clock),
      .reset (reset),
      .wr    (vtx_wr),
      .rd    (vtx_rd),
      .rd_x  (rd_x),
      .rd_y  (rd_y)
   );

   cpa_finish u_finish (
      .clock       (clock),
      .reset       (reset),
      .start       (do_finish),
      .rd_x        (rd_x),
      .rd_y        (rd_y),
      .rd          (vtx_rd),
      .busy        (busy),
      .bounds      (bounds),
      .shape_valid (shape_valid),
      .shape_area  (shape_area),
      .fin_rsp     (fin_rsp)
   );

   cpa_hit u_hit (
      .b           (bounds),
      .shape_valid (shape_valid),
      .x           (px),
      .y           (py),
      .inside_res  (hit_inside),
      .on_edge     (hit_edge)
   );

   // result strobe; a finish report and a query answer never meet because
   // no word is taken while the finish sequencer runs
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= fin_rsp.done || do_query;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (fin_rsp.done) begin
         kind_ff   <= KIND_AREA;
         valid_ff  <= fin_rsp.valid;
         area_ff   <= fin_rsp.area;
         inside_ff <= 1'b0;
         edge_ff   <= 1'b0;
      end else if (do_query) begin
         kind_ff   <= KIND_QUERY;
         valid_ff  <= shape_valid;
         area_ff   <= shape_area;
         inside_ff <= hit_inside;
         edge_ff   <= hit_edge;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_shape_valid = valid_ff;
   assign rsp_area        = area_ff;
   assign rsp_inside_res  = inside_ff;
   assign rsp_on_edge     = edge_ff;

   // a finish word must lock out the input side at once
   a_finish_busy: assert property (@(posedge clock) disable iff (reset)
      do_finish |=> busy)
      else $error("finish word taken but busy not raised");

   // a query answer follows its word in the next cycle
   a_query_rsp: assert property (@(posedge clock) disable iff (reset)
      do_query |=> (rsp_strobe && rsp_result_kind == KIND_QUERY))
      else $error("query word without answer");

   // an invalid shape reports nothing but zeros
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_shape_valid) |->
         (rsp_area == '0 && !rsp_inside_res && !rsp_on_edge))
      else $error("invalid shape with nonzero answer");

   // an area report carries no hit flags
   a_area_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_result_kind == KIND_AREA) |-> (!rsp_inside_res && !rsp_on_edge))
      else $error("area report with hit flags set");

endmodule

// File: tb/cross_polygon_area_and_hit_test_tb.sv
// Self-checking bench for cross_polygon_area_and_hit_test: corner loads, finish and
// point queries, checked word by word against an in-bench plus-shape predictor.
// Depends on cpa_pkg and the RTL top level only.
module cross_polygon_area_and_hit_test_tb;
   import cpa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // one stimulus word; a drain entry holds the sender until all answers are back
   typedef struct {
      bit          drain;
      logic [1:0]  action;
      logic [3:0]  index;
      logic [15:0] px;
      logic [15:0] py;
   } shape_word_type;

   // one answer as the rsp_ ports should show it
   typedef struct {
      logic             kind;
      logic             valid;
      logic [AREA_W-1:0] area;
      logic             in_shape;
      logic             on_edge;
   } shape_answer_type;

   // dividing lines of the finished shape, kept wide so every compare is signed
   typedef struct {
      longint x_lo, x_hi, y_lo, y_hi;
      longint w_ylo, w_yhi, e_ylo, e_yhi;
      longint s_xlo, s_xhi, n_xlo, n_xhi;
      longint c_yhi, c_ylo, c_xlo, c_xhi;
   } cross_lines_type;

   // which of the six x and six y line values each corner of a cross uses:
   // x: x0 sl sh nl nh x3, y: y0 wl wh el eh y3
   localparam int CORNER_XSEL [NUM_CORNERS] = '{1, 2, 2, 5, 5, 4, 4, 3, 3, 0, 0, 1};
   localparam int CORNER_YSEL [NUM_CORNERS] = '{0, 0, 3, 3, 4, 4, 5, 5, 2, 2, 1, 1};

   localparam int IDLE_PCT    = 29;
   localparam int CALM_FIRST  = 700;    // start of the stretch of words sent with no sender gaps
   localparam int CALM_LAST   = 1000;
   localparam int WORD_TARGET = 1525;   // random part stops once the queue holds this many
   localparam int TAIL_CYCLES = 40;     // longer than a finish takes

   logic              clock;
   logic              reset            = 1'b1;
   logic              start            = 1'b0;
   logic              busy;
   logic [1:0]        req_action       = '0;
   logic [3:0]        req_vertex_index = '0;
   logic signed [15:0] req_point_x     = '0;
   logic signed [15:0] req_point_y     = '0;
   logic              rsp_strobe;
   logic              rsp_result_kind;
   logic              rsp_shape_valid;
   logic [AREA_W-1:0] rsp_area;
   logic              rsp_inside_res;
   logic              rsp_on_edge;

   cross_polygon_area_and_hit_test u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_vertex_index (req_vertex_index),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_shape_valid  (rsp_shape_valid),
      .rsp_area         (rsp_area),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_on_edge      (rsp_on_edge)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: own copy of the corner store and the finished shape
   // ---------------------------------------------------------------------
   coord_type         corner_x [NUM_CORNERS];
   coord_type         corner_y [NUM_CORNERS];
   cross_lines_type   lines;
   logic [AREA_W-1:0] held_area;
   logic              held_valid;

   shape_word_type   word_q[$];
   shape_answer_type pending_answers[$];
   shape_word_type   next_word;
   int               words_sent = 0;
   int               errors     = 0;

   // line values of the cross last drawn, used to build its corner loads and to aim queries near its lines
   int line_x [6];
   int line_y [6];

   function automatic longint min2(longint a, longint b);
      return (a < b) ? a : b;
   endfunction

   function automatic longint max2(longint a, longint b);
      return (a > b) ? a : b;
   endfunction

   task automatic clear_shape_model();
      for (int i = 0; i < NUM_CORNERS; i++) begin
         corner_x[i] = '0;
         corner_y[i] = '0;
      end
      lines      = '{default: 0};
      held_area  = '0;
      held_valid = 1'b0;
   endtask

   // Finish: extents, the two corners on each extreme, inner lines, area.
   // Any extreme with other than two corners leaves the shape invalid.
   task automatic settle_shape();
      longint xmin, xmax, ymin, ymax, total;
      longint wv [NUM_CORNERS];
      longint ev [NUM_CORNERS];
      longint sv [NUM_CORNERS];
      longint nv [NUM_CORNERS];
      int     nw, ne, ns, nn;
      xmin = corner_x[0];
      xmax = xmin;
      ymin = corner_y[0];
      ymax = ymin;
      nw = 0;
      ne = 0;
      ns = 0;
      nn = 0;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         xmin = min2(xmin, corner_x[i]);
         xmax = max2(xmax, corner_x[i]);
         ymin = min2(ymin, corner_y[i]);
         ymax = max2(ymax, corner_y[i]);
      end
      // the else keeps a zero-width shape from counting a corner on both sides
      for (int i = 0; i < NUM_CORNERS; i++) begin
         if (corner_x[i] == xmin) begin
            wv[nw] = corner_y[i];
            nw++;
         end else if (corner_x[i] == xmax) begin
            ev[ne] = corner_y[i];
            ne++;
         end
         if (corner_y[i] == ymin) begin
            sv[ns] = corner_x[i];
            ns++;
         end else if (corner_y[i] == ymax) begin
            nv[nn] = corner_x[i];
            nn++;
         end
      end
      if (nw != 2 || ne != 2 || ns != 2 || nn != 2) begin
         lines      = '{default: 0};
         held_area  = '0;
         held_valid = 1'b0;
      end else begin
         lines.x_lo  = xmin;
         lines.x_hi  = xmax;
         lines.y_lo  = ymin;
         lines.y_hi  = ymax;
         lines.w_ylo = min2(wv[0], wv[1]);
         lines.w_yhi = max2(wv[0], wv[1]);
         lines.e_ylo = min2(ev[0], ev[1]);
         lines.e_yhi = max2(ev[0], ev[1]);
         lines.s_xlo = min2(sv[0], sv[1]);
         lines.s_xhi = max2(sv[0], sv[1]);
         lines.n_xlo = min2(nv[0], nv[1]);
         lines.n_xhi = max2(nv[0], nv[1]);
         lines.c_yhi = max2(lines.w_yhi, lines.e_yhi);
         lines.c_ylo = min2(lines.w_ylo, lines.e_ylo);
         lines.c_xlo = min2(lines.n_xlo, lines.s_xlo);
         lines.c_xhi = max2(lines.n_xhi, lines.s_xhi);
         // north, south, west, east arms and the middle; exact sum, then clamp
         total = (lines.y_hi - lines.c_yhi) * (lines.n_xhi - lines.n_xlo)
               + (lines.c_ylo - lines.y_lo) * (lines.s_xhi - lines.s_xlo)
               + (lines.c_xlo - lines.x_lo) * (lines.w_yhi - lines.w_ylo)
               + (lines.x_hi - lines.c_xhi) * (lines.e_yhi - lines.e_ylo)
               + (lines.c_xhi - lines.c_xlo) * (lines.c_yhi - lines.c_ylo);
         if (total < 0)
            held_area = '0;
         else if (total > 64'sh0000_0000_FFFF_FFFF)
            held_area = '1;
         else
            held_area = total[AREA_W-1:0];
         held_valid = 1'b1;
      end
   endtask

   // arm tests in fixed order; the middle rectangle includes its bounds
   function automatic logic point_within(longint x, longint y);
      if (lines.x_lo < x && x <= lines.c_xlo)
         return lines.w_ylo < y && y < lines.w_yhi;
      if (lines.c_yhi <= y && y < lines.y_hi)
         return lines.n_xlo < x && x < lines.n_xhi;
      if (lines.c_xhi <= x && x < lines.x_hi)
         return lines.e_ylo < y && y < lines.e_yhi;
      if (lines.y_lo < y && y <= lines.c_ylo)
         return lines.s_xlo < x && x < lines.s_xhi;
      if (lines.c_ylo <= y && y <= lines.c_yhi)
         return lines.c_xlo <= x && x <= lines.c_xhi;
      return 1'b0;
   endfunction

   function automatic logic open_span(longint lo, longint v, longint hi);
      return lo < v && v < hi;
   endfunction

   // twelve open edge segments, corners excluded
   function automatic logic point_on_border(longint x, longint y);
      return (x == lines.x_hi  && open_span(lines.e_ylo, y, lines.e_yhi))
          || (x == lines.x_lo  && open_span(lines.w_ylo, y, lines.w_yhi))
          || (x == lines.n_xlo && open_span(lines.w_yhi, y, lines.y_hi))
          || (x == lines.n_xhi && open_span(lines.e_yhi, y, lines.y_hi))
          || (x == lines.s_xlo && open_span(lines.y_lo, y, lines.w_ylo))
          || (x == lines.s_xhi && open_span(lines.y_lo, y, lines.e_ylo))
          || (y == lines.y_hi  && open_span(lines.n_xlo, x, lines.n_xhi))
          || (y == lines.y_lo  && open_span(lines.s_xlo, x, lines.s_xhi))
          || (y == lines.w_yhi && open_span(lines.x_lo, x, lines.n_xlo))
          || (y == lines.w_ylo && open_span(lines.x_lo, x, lines.s_xlo))
          || (y == lines.e_yhi && open_span(lines.n_xhi, x, lines.x_hi))
          || (y == lines.e_ylo && open_span(lines.s_xhi, x, lines.x_hi));
   endfunction

   // apply one accepted word to the model; queue the answer it causes, if any
   task automatic predict_cross_answer(input logic [1:0] action, input logic [3:0] index,
                                       input coord_type px, input coord_type py);
      shape_answer_type ans;
      case (action_type'(action))
         ACT_LOAD: begin
            if (index < NUM_CORNERS) begin
               corner_x[index] = px;
               corner_y[index] = py;
            end
         end
         ACT_FINISH: begin
            settle_shape();
            ans.kind     = KIND_AREA;
            ans.valid    = held_valid;
            ans.area     = held_area;
            ans.in_shape = 1'b0;
            ans.on_edge  = 1'b0;
            pending_answers.insert(pending_answers.size(), ans);
         end
         ACT_QUERY: begin
            ans.kind     = KIND_QUERY;
            ans.valid    = held_valid;
            ans.area     = held_area;
            ans.in_shape = held_valid && point_within(px, py);
            ans.on_edge  = held_valid && point_on_border(px, py);
            pending_answers.insert(pending_answers.size(), ans);
         end
         default: ;   // action three does nothing
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Driver: one word per accepted start; gaps at random except in the calm
   // stretch; holds the word while busy; a drain entry waits for all answers.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         clear_shape_model();
      end else if (!(start && busy)) begin
         if (start)
            predict_cross_answer(req_action, req_vertex_index, req_point_x, req_point_y);
         if (word_q.size() > 0 && word_q[0].drain) begin
            start <= 1'b0;
            if (pending_answers.size() == 0 && !busy && !start)
               void'(word_q.pop_front());
         end else if (word_q.size() > 0 &&
                      ((words_sent >= CALM_FIRST && words_sent < CALM_LAST) ||
                       $urandom_range(99) >= IDLE_PCT)) begin
            next_word = word_q.pop_front();
            start            <= 1'b1;
            req_action       <= next_word.action;
            req_vertex_index <= next_word.index;
            req_point_x      <= next_word.px;
            req_point_y      <= next_word.py;
            words_sent++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: each strobe is one result word, checked against the oldest answer
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input logic [AREA_W-1:0] want,
                              input logic [AREA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      shape_answer_type want;
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) begin
            $error("rsp_strobe: result word with no answer pending");
            errors++;
         end else begin
            want = pending_answers.pop_front();
            check_field("rsp_result_kind", want.kind,     rsp_result_kind);
            check_field("rsp_shape_valid", want.valid,    rsp_shape_valid);
            check_field("rsp_area",        want.area,     rsp_area);
            check_field("rsp_inside_res",  want.in_shape, rsp_inside_res);
            check_field("rsp_on_edge",     want.on_edge,  rsp_on_edge);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------
   function automatic int rand_in(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   task automatic add_word(input action_type action, input int index, input int x,
                           input int y);
      shape_word_type w;
      w.drain  = 1'b0;
      w.action = action;
      w.index  = index[3:0];
      w.px     = x[15:0];
      w.py     = y[15:0];
      word_q.insert(word_q.size(), w);
   endtask

   // two distinct values strictly between lo and hi, ascending
   task automatic inner_pair(input int lo, input int hi, output int a, output int b);
      int p, q;
      p = rand_in(lo + 1, hi - 1);
      do q = rand_in(lo + 1, hi - 1); while (q == p);
      a = (p < q) ? p : q;
      b = (p < q) ? q : p;
   endtask

   // fresh random cross into line_x / line_y; mostly small, a few full range
   task automatic draw_cross();
      int pick, lo, hi;
      pick = $urandom_range(99);
      for (int axis = 0; axis < 2; axis++) begin
         if (pick < 55) begin
            lo = rand_in(-64, 0);
            hi = lo + rand_in(4, 64);
         end else if (pick < 85) begin
            lo = rand_in(-3000, 0);
            hi = lo + rand_in(4, 3000);
         end else begin
            lo = rand_in(-32768, -32000);
            hi = rand_in(32000, 32767);
         end
         if (axis == 0) begin
            line_x[0] = lo;
            line_x[5] = hi;
            inner_pair(lo, hi, line_x[1], line_x[2]);
            inner_pair(lo, hi, line_x[3], line_x[4]);
         end else begin
            line_y[0] = lo;
            line_y[5] = hi;
            inner_pair(lo, hi, line_y[1], line_y[2]);
            inner_pair(lo, hi, line_y[3], line_y[4]);
         end
      end
   endtask

   // query aimed near a line of the current cross, or anywhere
   task automatic add_query();
      if ($urandom_range(99) < 15)
         add_word(ACT_QUERY, $urandom_range(15), rand_in(-32768, 32767),
                  rand_in(-32768, 32767));
      else
         add_word(ACT_QUERY, $urandom_range(15), line_x[$urandom_range(5)] + rand_in(-1, 1),
                  line_y[$urandom_range(5)] + rand_in(-1, 1));
   endtask

   // load_count loads of the current cross in shuffled order, with stray words
   // between; some rounds break it by loading only part of it or corrupting corners
   task automatic add_cross_loads(input int load_count, input int corrupt_count);
      int order [NUM_CORNERS];
      int j, t;
      for (int i = 0; i < NUM_CORNERS; i++) order[i] = i;
      for (int i = NUM_CORNERS - 1; i > 0; i--) begin
         j = $urandom_range(i);
         t = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      for (int i = 0; i < load_count; i++) begin
         add_word(ACT_LOAD, order[i], line_x[CORNER_XSEL[order[i]]],
                  line_y[CORNER_YSEL[order[i]]]);
         t = $urandom_range(99);
         if (t < 8)
            add_query();
         else if (t < 12)
            add_word(ACT_LOAD, rand_in(NUM_CORNERS, 15), rand_in(-32768, 32767),
                     rand_in(-32768, 32767));
         else if (t < 14)
            add_word(ACT_NONE, $urandom_range(15), rand_in(-32768, 32767),
                     rand_in(-32768, 32767));
      end
      for (int i = 0; i < corrupt_count; i++)
         add_word(ACT_LOAD, $urandom_range(LAST_CORNER), rand_in(-32768, 32767),
                  rand_in(-32768, 32767));
   endtask

   // corners drawn from a few shared values so extremes collide
   task automatic add_pooled_corners();
      int pool [6];
      pool = '{-32768, -1, 0, 1, 32767, rand_in(-32768, 32767)};
      for (int i = 0; i < NUM_CORNERS; i++)
         add_word(ACT_LOAD, i, pool[$urandom_range(5)], pool[$urandom_range(5)]);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence: build the whole word list, release reset, drain, report
   // ---------------------------------------------------------------------
   initial begin
      shape_word_type hold;
      int             rounds, kind, wait_cycles;

      // directed: invalid shape before any finish and after an all-zero finish
      add_word(ACT_QUERY, 0, 0, 0);
      add_word(ACT_FINISH, 0, 0, 0);
      // dropped loads and the unused action, at the coordinate extremes
      add_word(ACT_LOAD, 15, -32768, 32767);
      add_word(ACT_LOAD, NUM_CORNERS, 32767, -32768);
      add_word(ACT_NONE, 15, 32767, -32768);
      // full-range plus, loaded in order, then its area
      line_x = '{-32768, -100, 200, -100, 200, 32767};
      line_y = '{-32768, -50, 300, -50, 300, 32767};
      for (int i = 0; i < NUM_CORNERS; i++)
         add_word(ACT_LOAD, i, line_x[CORNER_XSEL[i]], line_y[CORNER_YSEL[i]]);
      add_word(ACT_FINISH, 0, 0, 0);
      add_word(ACT_QUERY, 0, 0, 0);               // middle
      add_word(ACT_QUERY, 1, -32767, 0);          // west arm
      add_word(ACT_QUERY, 2, -32768, 100);        // west edge, not inside
      add_word(ACT_QUERY, 3, -32768, -50);        // corner: not an open edge
      add_word(ACT_QUERY, 4, 150, 32767);         // north edge
      add_word(ACT_QUERY, 15, 32767, 32767);      // bounding-box corner, outside

      // random rounds: mostly whole crosses with random content, then queries
      rounds = 0;
      while (word_q.size() < WORD_TARGET) begin
         kind = $urandom_range(99);
         if (kind < 70) begin
            draw_cross();
            add_cross_loads(NUM_CORNERS, 0);
         end else if (kind < 85) begin
            draw_cross();
            add_cross_loads(NUM_CORNERS, rand_in(1, 2));
         end else if (kind < 95) begin
            add_pooled_corners();
         end else begin
            draw_cross();
            add_cross_loads(rand_in(1, 6), 0);
         end
         add_word(ACT_FINISH, $urandom_range(15), rand_in(-32768, 32767),
                  rand_in(-32768, 32767));
         repeat (rand_in(8, 30)) add_query();
         rounds++;
         // one pause with every answer back before the next word goes out
         if (rounds == 12) begin
            hold = '{drain: 1'b1, default: '0};
            word_q.insert(word_q.size(), hold);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // sample at the falling edge so driver updates have settled
      while (word_q.size() != 0 || start) @(negedge clock);
      wait_cycles = 0;
      while (pending_answers.size() != 0 && wait_cycles < 4000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_answers.size() != 0) begin
         $error("rsp_strobe: %0d answers never arrived", pending_answers.size());
         errors++;
      end
      if (errors == 0)
         $display("cross_polygon_area_and_hit_test regression: pass");
      else
         $display("cross_polygon_area_and_hit_test regression: fail");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #1000000;
      $display("cross_polygon_area_and_hit_test regression: fail");
      $finish;
   end

endmodule

// File: cross_polygon_area_and_hit_test.f
design/cpa_pkg.sv
design/cpa_vertex_ram.sv
design/cpa_finish.sv
design/cpa_hit.sv
design/cross_polygon_area_and_hit_test.sv
tb/cross_polygon_area_and_hit_test_tb.sv
